// ===== rtl/pneumatic_command_decoder_defines.svh =====
// Assertion macros shared by the pneumatic command decoder RTL.
`ifndef PNEUMATIC_COMMAND_DECODER_DEFINES_SVH
`define PNEUMATIC_COMMAND_DECODER_DEFINES_SVH

// Clocked check, switched off while reset is asserted.
`define PCD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked check that also holds through reset.
`define PCD_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/pcd_pkg.sv =====
// Shared widths, command codes, mode codes and state type of the pneumatic command decoder.
package pcd_pkg;

	localparam int PORT_COUNT_DEF = 5;
	localparam int VS_PORTS       = 5;
	localparam int BYTE_W         = 8;
	localparam int MODE_W         = 3;
	localparam int VS_W           = 11;
	localparam int REQ_W          = 2;

	// Command characters
	localparam logic [BYTE_W-1:0] ACT_STOP     = 8'h21; // '!'
	localparam logic [BYTE_W-1:0] ACT_INFLATE  = 8'h2B; // '+'
	localparam logic [BYTE_W-1:0] ACT_VACUUM   = 8'h2D; // '-'
	localparam logic [BYTE_W-1:0] ACT_INF_HALF = 8'h70; // 'p'
	localparam logic [BYTE_W-1:0] ACT_VAC_HALF = 8'h6E; // 'n'
	localparam logic [BYTE_W-1:0] ACT_RELEASE  = 8'h5E; // '^'
	localparam logic [BYTE_W-1:0] ACT_OPEN     = 8'h6F; // 'o'
	localparam logic [BYTE_W-1:0] ACT_CLOSE    = 8'h63; // 'c'
	localparam logic [BYTE_W-1:0] ACT_POWER    = 8'h66; // 'f'
	localparam logic [BYTE_W-1:0] ACT_RED      = 8'h72; // 'r'
	localparam logic [BYTE_W-1:0] ACT_BLUE     = 8'h62; // 'b'
	localparam logic [BYTE_W-1:0] ACT_QUERY    = 8'h3F; // '?'

	// Plumbing modes
	localparam logic [MODE_W-1:0] MODE_GENERAL = 3'd0;
	localparam logic [MODE_W-1:0] MODE_INF_SER = 3'd1;
	localparam logic [MODE_W-1:0] MODE_INF_PAR = 3'd2;
	localparam logic [MODE_W-1:0] MODE_VAC_SER = 3'd3;
	localparam logic [MODE_W-1:0] MODE_VAC_PAR = 3'd4;

	// Pressure request codes
	localparam logic [REQ_W-1:0] REQ_NONE    = 2'd0;
	localparam logic [REQ_W-1:0] REQ_NOW     = 2'd1;
	localparam logic [REQ_W-1:0] REQ_ISOLATE = 2'd2;

	// Controller state apart from the port valves
	typedef struct packed {
		logic              inlet;
		logic              outlet;
		logic [BYTE_W-1:0] pump_one;
		logic [BYTE_W-1:0] pump_two;
		logic [1:0]        led;
		logic              latch;
	} ctrl_t;

endpackage

// ===== rtl/pcd_cfg_if.sv =====
// Configuration write channel carrying the plumbing mode.
interface pcd_cfg_if import pcd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [MODE_W-1:0] data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== rtl/pcd_cmd_if.sv =====
// Command channel: one three-byte command per item.
interface pcd_cmd_if import pcd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] action;
	logic [BYTE_W-1:0] port_mask;
	logic [BYTE_W-1:0] pump_duty;

	modport source(output valid, output action, output port_mask, output pump_duty,
		input ready);
	modport sink(input valid, input action, input port_mask, input pump_duty,
		output ready);
endinterface

// ===== rtl/pcd_res_if.sv =====
// Result channel: packed state, pump duties, power-off and pressure request.
interface pcd_res_if import pcd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [VS_W-1:0]   valve_state;
	logic [BYTE_W-1:0] pump_one_duty;
	logic [BYTE_W-1:0] pump_two_duty;
	logic              power_off;
	logic [REQ_W-1:0]  pressure_request;

	modport source(output valid, output valve_state, output pump_one_duty,
		output pump_two_duty, output power_off, output pressure_request, input ready);
	modport sink(input valid, input valve_state, input pump_one_duty,
		input pump_two_duty, input power_off, input pressure_request, output ready);
endinterface

// ===== rtl/pcd_decode.sv =====
// Command decoder: next controller state, packed valve word and pressure request.
module pcd_decode import pcd_pkg::*; #(
	parameter int PORT_COUNT = PORT_COUNT_DEF
) (
	input  logic [MODE_W-1:0]     mode,
	input  ctrl_t                 cur,
	input  logic [PORT_COUNT-1:0] ports_cur,
	input  logic [BYTE_W-1:0]     action,
	input  logic [BYTE_W-1:0]     port_mask,
	input  logic [BYTE_W-1:0]     pump_duty,
	output ctrl_t                 nxt,
	output logic [PORT_COUNT-1:0] ports_nxt,
	output logic [VS_W-1:0]       valve_state,
	output logic [REQ_W-1:0]      req
);

	logic [PORT_COUNT-1:0]          sel;
	logic                           any;
	logic                           infl_side;
	logic                           infl_only;
	logic                           vac_side;
	logic                           vac_only;
	ctrl_t                          halt_c;
	logic [PORT_COUNT-1:0]          ports_halt;
	logic [VS_PORTS+PORT_COUNT-1:0] ports_ext;

	// Select ports, classify the mode and form the halt state
	always_comb begin
		sel        = port_mask[PORT_COUNT-1:0];
		any        = |sel;
		infl_side  = mode inside {MODE_GENERAL, MODE_INF_SER, MODE_INF_PAR};
		infl_only  = mode inside {MODE_INF_SER, MODE_INF_PAR};
		vac_side   = mode inside {MODE_GENERAL, MODE_VAC_SER, MODE_VAC_PAR};
		vac_only   = mode inside {MODE_VAC_SER, MODE_VAC_PAR};
		halt_c          = cur;
		halt_c.inlet    = 1'b0;
		halt_c.outlet   = 1'b0;
		halt_c.pump_one = '0;
		halt_c.pump_two = '0;
		ports_halt      = ports_cur & ~sel;
	end

	// Decode the command
	always_comb begin
		nxt       = cur;
		ports_nxt = ports_cur;
		req       = REQ_NONE;
		case (action)
			ACT_STOP: begin
				nxt       = halt_c;
				ports_nxt = ports_halt;
			end
			ACT_INFLATE: begin
				nxt       = halt_c;
				ports_nxt = ports_halt;
				if (infl_side && any) begin
					nxt.inlet    = 1'b1;
					ports_nxt    = sel;
					nxt.pump_one = pump_duty;
					if (mode != MODE_GENERAL) begin
						nxt.pump_two = pump_duty;
					end
				end
			end
			ACT_INF_HALF: begin
				nxt       = halt_c;
				ports_nxt = ports_halt;
				if (infl_only && any) begin
					nxt.inlet    = 1'b1;
					ports_nxt    = sel;
					nxt.pump_one = pump_duty;
				end
			end
			ACT_VACUUM: begin
				nxt       = halt_c;
				ports_nxt = ports_halt;
				if (vac_side && any) begin
					nxt.outlet   = 1'b1;
					ports_nxt    = sel;
					nxt.pump_two = pump_duty;
					if (mode != MODE_GENERAL) begin
						nxt.pump_one = pump_duty;
					end
				end
			end
			ACT_VAC_HALF: begin
				nxt       = halt_c;
				ports_nxt = ports_halt;
				if (vac_only && any) begin
					nxt.outlet   = 1'b1;
					ports_nxt    = sel;
					nxt.pump_one = pump_duty;
				end
			end
			ACT_RELEASE: begin
				nxt       = halt_c;
				ports_nxt = ports_halt;
				if (any) begin
					ports_nxt = sel;
					if (infl_side) begin
						nxt.outlet = 1'b1;
					end else begin
						nxt.inlet = 1'b1;
					end
				end
			end
			ACT_OPEN: begin
				ports_nxt = ports_cur | sel;
			end
			ACT_CLOSE: begin
				ports_nxt = ports_halt;
			end
			ACT_POWER: begin
				if (port_mask == ACT_POWER) begin
					nxt.latch = 1'b1;
				end
			end
			ACT_RED: begin
				nxt.led[0] = |port_mask;
			end
			ACT_BLUE: begin
				nxt.led[1] = |port_mask;
			end
			ACT_QUERY: begin
				if (port_mask == ACT_QUERY) begin
					req = REQ_NOW;
				end else begin
					nxt       = halt_c;
					ports_nxt = sel;
					req       = REQ_ISOLATE;
				end
			end
			default: begin
				req = REQ_NONE;
			end
		endcase
	end

	// Pack the state word; only the first five ports are shown
	always_comb begin
		ports_ext   = {{VS_PORTS{1'b0}}, ports_nxt};
		valve_state = {nxt.led[1], nxt.led[0], |nxt.pump_two, |nxt.pump_one,
			nxt.outlet, nxt.inlet, ports_ext[VS_PORTS-1:0]};
	end

endmodule

// ===== rtl/pneumatic_command_decoder.sv =====
// Top level of the pneumatic command decoder: input stage, controller state and result register.
//
// Takes one command item per clock while the result side is ready, and returns one result item per command.
// A command is captured in an input register, decoded against the
// controller state and the plumbing mode, and the new state is written back
// together with the result register in the same cycle. The state registers
// are updated once per item, which sets the rate: one item per clock with
// the result side ready.
// The plumbing mode register is written through the configuration channel,
// which is always ready; write it only while no command is in flight.
module pneumatic_command_decoder import pcd_pkg::*; #(
	parameter int PORT_COUNT = PORT_COUNT_DEF
) (
	input logic        clk,
	input logic        arst_n,
	pcd_cfg_if.sink    cfg,
	pcd_cmd_if.sink    cmd,
	pcd_res_if.source  res
);

`include "pneumatic_command_decoder_defines.svh"

	logic [MODE_W-1:0]     mode_q;
	ctrl_t                 ctrl_q;
	logic [PORT_COUNT-1:0] ports_q;

	logic                  valid_s1;
	logic [BYTE_W-1:0]     action_s1;
	logic [BYTE_W-1:0]     port_mask_s1;
	logic [BYTE_W-1:0]     pump_duty_s1;

	logic                  res_valid_q;
	logic [VS_W-1:0]       res_vs_q;
	logic [BYTE_W-1:0]     res_p1_q;
	logic [BYTE_W-1:0]     res_p2_q;
	logic                  res_off_q;
	logic [REQ_W-1:0]      res_req_q;

	logic                  adv;
	logic                  fire;
	ctrl_t                 ctrl_nxt;
	logic [PORT_COUNT-1:0] ports_nxt;
	logic [VS_W-1:0]       vs_nxt;
	logic [REQ_W-1:0]      req_nxt;

	// Handshake control
	assign adv       = !res_valid_q || res.ready;
	assign fire      = valid_s1 && adv;
	assign cmd.ready = !valid_s1 || adv;
	assign cfg.ready = 1'b1;

	// Hold the plumbing mode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_GENERAL;
		end else if (cfg.valid && cfg.ready) begin
			mode_q <= cfg.data;
		end
	end

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.valid && cmd.ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			action_s1    <= cmd.action;
			port_mask_s1 <= cmd.port_mask;
			pump_duty_s1 <= cmd.pump_duty;
		end
	end

	pcd_decode #(
		.PORT_COUNT(PORT_COUNT)
	) u_decode (
		.mode       (mode_q),
		.cur        (ctrl_q),
		.ports_cur  (ports_q),
		.action     (action_s1),
		.port_mask  (port_mask_s1),
		.pump_duty  (pump_duty_s1),
		.nxt        (ctrl_nxt),
		.ports_nxt  (ports_nxt),
		.valve_state(vs_nxt),
		.req        (req_nxt)
	);

	// Advance the controller state on each decoded item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q  <= '0;
			ports_q <= '0;
		end else if (fire) begin
			ctrl_q  <= ctrl_nxt;
			ports_q <= ports_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (fire) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_vs_q  <= vs_nxt;
			res_p1_q  <= ctrl_nxt.pump_one;
			res_p2_q  <= ctrl_nxt.pump_two;
			res_off_q <= ctrl_nxt.latch;
			res_req_q <= req_nxt;
		end
	end

	assign res.valid            = res_valid_q;
	assign res.valve_state      = res_vs_q;
	assign res.pump_one_duty    = res_p1_q;
	assign res.pump_two_duty    = res_p2_q;
	assign res.power_off        = res_off_q;
	assign res.pressure_request = res_req_q;

	// Checks
	`PCD_ASSERT(a_latch_sticks, $past(ctrl_q.latch) |-> ctrl_q.latch, "power-off latch cleared")
	`PCD_ASSERT(a_fire_gives_result, fire |=> res_valid_q, "decoded item gave no result")
	`PCD_ASSERT(a_ready_when_empty, !valid_s1 |-> cmd.ready, "input refused while stage empty")
	`PCD_ASSERT(a_run_bits, res_valid_q |-> (res_vs_q[8:7] == {|res_p2_q, |res_p1_q}), "pump bits wrong")
	`PCD_ASSERT_ALWAYS(a_idle_in_reset, !arst_n |=> !res_valid_q && !valid_s1, "item held in reset")

endmodule

// ===== dv/tb_top.sv =====
// Testbench for the pneumatic command decoder: a directed table, then random commands per mode.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import pcd_pkg::*;

	localparam int CLK_PERIOD    = 10;
	localparam int RESET_CYCLES  = 11;
	localparam int PORTS         = PORT_COUNT_DEF;
	localparam int PHASES        = 10;
	localparam int PHASE_ITEMS   = 65;
	localparam int SETTLE_CYCLES = 8;
	localparam int CYCLE_LIMIT   = 300000;
	localparam int REPORT_LIMIT  = 10;

	// Mode values beyond the defined plumbing layouts
	localparam logic [MODE_W-1:0] MODE_UNUSED_LO  = 3'd5;
	localparam logic [MODE_W-1:0] MODE_UNUSED_MID = 3'd6;
	localparam logic [MODE_W-1:0] MODE_UNUSED_HI  = 3'd7;

	localparam logic [BYTE_W-1:0] CMD_CODES [12] = '{ACT_STOP, ACT_INFLATE, ACT_VACUUM,
		ACT_INF_HALF, ACT_VAC_HALF, ACT_RELEASE, ACT_OPEN, ACT_CLOSE, ACT_POWER, ACT_RED,
		ACT_BLUE, ACT_QUERY};

	typedef struct packed {
		logic [VS_W-1:0]   valve_state;
		logic [BYTE_W-1:0] pump_one_duty;
		logic [BYTE_W-1:0] pump_two_duty;
		logic              power_off;
		logic [REQ_W-1:0]  pressure_request;
	} pcd_result_t;

	typedef struct {
		logic [MODE_W-1:0] mode;
		logic [BYTE_W-1:0] action;
		logic [BYTE_W-1:0] port_mask;
		logic [BYTE_W-1:0] pump_duty;
		bit                fixed;
		pcd_result_t       result;
	} cmd_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	pcd_cfg_if cfg_if();
	pcd_cmd_if cmd_if();
	pcd_res_if res_if();

	pneumatic_command_decoder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_if),
		.cmd    (cmd_if),
		.res    (res_if)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Controller state as the predictor sees it
	logic [MODE_W-1:0] cur_mode = MODE_GENERAL;
	logic [PORTS-1:0]  port_valves = '0;
	ctrl_t             ctl_state = '0;

	pcd_result_t pending_results[$];
	int          commands_sent = 0;
	int          results_checked = 0;
	int          mismatches = 0;
	int          mode_writes = 0;
	int          hold_request = 0;
	int          burst_left = 0;
	bit          calm = 1'b0;

	// Close inlet, outlet and the selected ports, stop both pumps
	function automatic void halt_all(input logic [PORTS-1:0] sel);
		ctl_state.inlet = 1'b0;
		ctl_state.outlet = 1'b0;
		ctl_state.pump_one = '0;
		ctl_state.pump_two = '0;
		port_valves &= ~sel;
	endfunction

	// Apply one command to the predicted state and return the result it yields
	function automatic pcd_result_t decode_command(input logic [BYTE_W-1:0] act, arg, duty);
		logic [PORTS-1:0] sel;
		logic             any_port;
		logic             infl_side;
		logic             infl_only;
		logic             vac_side;
		logic             vac_only;
		logic [REQ_W-1:0] req;
		pcd_result_t      r;
		sel = arg[PORTS-1:0];
		any_port = |sel;
		infl_side = cur_mode <= MODE_INF_PAR;
		infl_only = cur_mode == MODE_INF_SER || cur_mode == MODE_INF_PAR;
		vac_only = cur_mode == MODE_VAC_SER || cur_mode == MODE_VAC_PAR;
		vac_side = cur_mode == MODE_GENERAL || vac_only;
		req = REQ_NONE;
		case (act)
			ACT_STOP: halt_all(sel);
			ACT_INFLATE: begin
				halt_all(sel);
				if (infl_side && any_port) begin
					ctl_state.inlet = 1'b1;
					port_valves = sel;
					ctl_state.pump_one = duty;
					if (cur_mode != MODE_GENERAL)
						ctl_state.pump_two = duty;
				end
			end
			ACT_INF_HALF: begin
				halt_all(sel);
				if (infl_only && any_port) begin
					ctl_state.inlet = 1'b1;
					port_valves = sel;
					ctl_state.pump_one = duty;
				end
			end
			ACT_VACUUM: begin
				halt_all(sel);
				if (vac_side && any_port) begin
					ctl_state.outlet = 1'b1;
					port_valves = sel;
					ctl_state.pump_two = duty;
					if (cur_mode != MODE_GENERAL)
						ctl_state.pump_one = duty;
				end
			end
			ACT_VAC_HALF: begin
				halt_all(sel);
				if (vac_only && any_port) begin
					ctl_state.outlet = 1'b1;
					port_valves = sel;
					ctl_state.pump_one = duty;
				end
			end
			ACT_RELEASE: begin
				halt_all(sel);
				if (any_port) begin
					port_valves = sel;
					if (infl_side)
						ctl_state.outlet = 1'b1;
					else
						ctl_state.inlet = 1'b1;
				end
			end
			ACT_OPEN: port_valves |= sel;
			ACT_CLOSE: port_valves &= ~sel;
			ACT_POWER: begin
				if (arg == ACT_POWER)
					ctl_state.latch = 1'b1;
			end
			ACT_RED: ctl_state.led[0] = |arg;
			ACT_BLUE: ctl_state.led[1] = |arg;
			ACT_QUERY: begin
				if (arg == ACT_QUERY) begin
					req = REQ_NOW;
				end else begin
					ctl_state.inlet = 1'b0;
					ctl_state.outlet = 1'b0;
					ctl_state.pump_one = '0;
					ctl_state.pump_two = '0;
					port_valves = sel;
					req = REQ_ISOLATE;
				end
			end
			default: ;
		endcase
		r.valve_state = {ctl_state.led[1], ctl_state.led[0], |ctl_state.pump_two,
			|ctl_state.pump_one, ctl_state.outlet, ctl_state.inlet, port_valves[VS_PORTS-1:0]};
		r.pump_one_duty = ctl_state.pump_one;
		r.pump_two_duty = ctl_state.pump_two;
		r.power_off = ctl_state.latch;
		r.pressure_request = req;
		return r;
	endfunction

	// Mostly no gap, some short ones, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		else if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Draw a command: mostly known actions, with argument bytes biased to the edges
	function automatic void random_command(input bit allow_off, output logic [BYTE_W-1:0] act,
		output logic [BYTE_W-1:0] arg, output logic [BYTE_W-1:0] duty);
		int r;
		r = $urandom_range(0, 99);
		if (r < 88)
			act = CMD_CODES[$urandom_range(0, 11)];
		else
			act = BYTE_W'($urandom_range(0, 255));
		r = $urandom_range(0, 99);
		if (r < 15)
			arg = 8'h00;
		else if (r < 25)
			arg = {3'($urandom_range(1, 7)), 5'b0};
		else if (r < 32)
			arg = 8'hFF;
		else
			arg = BYTE_W'($urandom_range(0, 255));
		if (act == ACT_QUERY && $urandom_range(0, 3) == 0)
			arg = ACT_QUERY;
		if (act == ACT_POWER && allow_off && $urandom_range(0, 2) == 0)
			arg = ACT_POWER;
		if (act == ACT_POWER && arg == ACT_POWER && !allow_off)
			arg = 8'h00;
		r = $urandom_range(0, 99);
		if (r < 10)
			duty = 8'h00;
		else if (r < 18)
			duty = 8'hFF;
		else
			duty = BYTE_W'($urandom_range(0, 255));
	endfunction

	function automatic void log_mismatch(input string why, input pcd_result_t exp,
		input pcd_result_t got);
		mismatches++;
		if (mismatches <= REPORT_LIMIT)
			$display("%0t: %s at result %0d:", $realtime, why, results_checked,
				" expected vs=%h p1=%h p2=%h off=%b req=%0d,", exp.valve_state,
				exp.pump_one_duty, exp.pump_two_duty, exp.power_off, exp.pressure_request,
				" got vs=%h p1=%h p2=%h off=%b req=%0d", got.valve_state,
				got.pump_one_duty, got.pump_two_duty, got.power_off, got.pressure_request);
	endfunction

	// Offer one command after a random gap; predict its result once it is taken
	task automatic send_command(input logic [BYTE_W-1:0] act, arg, duty, input bit fixed,
		input pcd_result_t fixed_result);
		int          gap;
		pcd_result_t predicted;
		if (burst_left > 0) begin
			gap = 0;
			burst_left--;
		end else begin
			gap = calm ? 0 : pick_gap();
		end
		if (gap > 0) begin
			cmd_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_if.valid <= 1'b1;
		cmd_if.action <= act;
		cmd_if.port_mask <= arg;
		cmd_if.pump_duty <= duty;
		do @(posedge clk); while (!cmd_if.ready);
		predicted = decode_command(act, arg, duty);
		pending_results.push_back(fixed ? fixed_result : predicted);
		commands_sent++;
	endtask

	// Drop the command valid and hold until every result is back
	task automatic drain_results();
		cmd_if.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic write_mode(input logic [MODE_W-1:0] mode);
		drain_results();
		cfg_if.valid <= 1'b1;
		cfg_if.data <= mode;
		do @(posedge clk); while (!cfg_if.ready);
		cfg_if.valid <= 1'b0;
		cur_mode = mode;
		mode_writes++;
	endtask

	// Result side: random stalls, plus a long hold-off when asked
	initial begin : result_sink
		int stall_left;
		stall_left = 0;
		res_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request > 0) begin
				stall_left = hold_request;
				hold_request = 0;
			end
			if (stall_left > 0) begin
				res_if.ready <= 1'b0;
				stall_left--;
			end else begin
				res_if.ready <= 1'b1;
				stall_left = calm ? 0 : pick_gap();
			end
		end
	end

	// Compare each taken result with the oldest prediction
	always @(posedge clk) begin
		pcd_result_t got;
		pcd_result_t exp;
		if (arst_n && res_if.valid && res_if.ready) begin
			got = '{res_if.valve_state, res_if.pump_one_duty, res_if.pump_two_duty,
				res_if.power_off, res_if.pressure_request};
			if (pending_results.size() == 0) begin
				log_mismatch("unexpected result", '0, got);
			end else begin
				exp = pending_results.pop_front();
				if (got.valve_state !== exp.valve_state
					|| got.pump_one_duty !== exp.pump_one_duty
					|| got.pump_two_duty !== exp.pump_two_duty
					|| got.power_off !== exp.power_off
					|| got.pressure_request !== exp.pressure_request)
					log_mismatch("mismatch", exp, got);
			end
			results_checked++;
		end
	end

	// Stop a hung run
	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles, %0d results outstanding", cycles,
			pending_results.size());
		$display("FAIL");
		$finish;
	end

	initial begin : stimulus
		cmd_row_t          directed_rows[$];
		logic [MODE_W-1:0] phase_modes[PHASES];
		logic [BYTE_W-1:0] act;
		logic [BYTE_W-1:0] arg;
		logic [BYTE_W-1:0] duty;
		int                directed_count;

		cmd_if.valid <= 1'b0;
		cmd_if.action <= '0;
		cmd_if.port_mask <= '0;
		cmd_if.pump_duty <= '0;
		cfg_if.valid <= 1'b0;
		cfg_if.data <= '0;

		// Reset state, fixed answers first, then every action and special case
		directed_rows.push_back('{MODE_GENERAL, 8'h00, 8'h00, 8'h00, 1'b1,
			'{11'h000, 8'h00, 8'h00, 1'b0, REQ_NONE}});
		directed_rows.push_back('{MODE_GENERAL, ACT_QUERY, ACT_QUERY, 8'h00, 1'b1,
			'{11'h000, 8'h00, 8'h00, 1'b0, REQ_NOW}});
		directed_rows.push_back('{MODE_GENERAL, ACT_INFLATE, 8'hFF, 8'hFF, 1'b1,
			'{11'h0BF, 8'hFF, 8'h00, 1'b0, REQ_NONE}});
		directed_rows.push_back('{MODE_GENERAL, ACT_STOP, 8'h00, 8'h00, 1'b0, '0});
		directed_rows.push_back('{MODE_GENERAL, ACT_STOP, 8'h03, 8'hFF, 1'b0, '0});
		directed_rows.push_back('{MODE_GENERAL, ACT_VACUUM, 8'h01, 8'h80, 1'b0, '0});
		// only bits above the ports: nothing selected
		directed_rows.push_back('{MODE_GENERAL, ACT_VACUUM, 8'hE0, 8'hFF, 1'b0, '0});
		// pump started at zero duty
		directed_rows.push_back('{MODE_GENERAL, ACT_INFLATE, 8'h10, 8'h00, 1'b0, '0});
		directed_rows.push_back('{MODE_GENERAL, ACT_OPEN, 8'h15, 8'h00, 1'b0, '0});
		directed_rows.push_back('{MODE_GENERAL, ACT_CLOSE, 8'h04, 8'h00, 1'b0, '0});
		directed_rows.push_back('{MODE_GENERAL, ACT_RELEASE, 8'h0A, 8'h00, 1'b0, '0});
		directed_rows.push_back('{MODE_GENERAL, ACT_RED, 8'hFF, 8'h00, 1'b0, '0});
		directed_rows.push_back('{MODE_GENERAL, ACT_BLUE, 8'h01, 8'h00, 1'b0, '0});
		directed_rows.push_back('{MODE_GENERAL, ACT_RED, 8'h00, 8'h00, 1'b0, '0});
		// power-off with a wrong argument leaves the latch clear
		directed_rows.push_back('{MODE_GENERAL, ACT_POWER, 8'h00, 8'h00, 1'b0, '0});
		directed_rows.push_back('{MODE_GENERAL, ACT_POWER, 8'h67, 8'h00, 1'b0, '0});
		directed_rows.push_back('{MODE_GENERAL, ACT_QUERY, 8'hA5, 8'h77, 1'b0, '0});
		directed_rows.push_back('{MODE_INF_SER, ACT_INF_HALF, 8'h1F, 8'h55, 1'b0, '0});
		directed_rows.push_back('{MODE_INF_PAR, ACT_INFLATE, 8'h07, 8'h01, 1'b0, '0});
		directed_rows.push_back('{MODE_VAC_SER, ACT_VAC_HALF, 8'h1F, 8'hAA, 1'b0, '0});
		directed_rows.push_back('{MODE_VAC_PAR, ACT_VACUUM, 8'h08, 8'hFE, 1'b0, '0});
		directed_rows.push_back('{MODE_VAC_SER, ACT_RELEASE, 8'h11, 8'h00, 1'b0, '0});
		// unused modes: only the stop part acts, release opens the inlet
		directed_rows.push_back('{MODE_UNUSED_HI, ACT_INFLATE, 8'h1F, 8'h40, 1'b0, '0});
		directed_rows.push_back('{MODE_UNUSED_LO, ACT_RELEASE, 8'h02, 8'h00, 1'b0, '0});
		directed_rows.push_back('{MODE_UNUSED_MID, ACT_VAC_HALF, 8'hFF, 8'hFF, 1'b0, '0});

		phase_modes = '{MODE_GENERAL, MODE_VAC_PAR, MODE_INF_SER, MODE_INF_PAR, MODE_VAC_SER,
			MODE_UNUSED_HI, MODE_UNUSED_LO, MODE_UNUSED_MID, 3'($urandom_range(0, 4)),
			MODE_GENERAL};

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table, changing mode only with nothing in flight
		foreach (directed_rows[i]) begin
			if (directed_rows[i].mode != cur_mode)
				write_mode(directed_rows[i].mode);
			send_command(directed_rows[i].action, directed_rows[i].port_mask,
				directed_rows[i].pump_duty, directed_rows[i].fixed, directed_rows[i].result);
		end
		directed_count = commands_sent;

		// Random phases, one per mode setting
		for (int p = 0; p < PHASES; p++) begin
			if (phase_modes[p] != cur_mode)
				write_mode(phase_modes[p]);
			calm = (p == 2);
			if (p == 3) begin
				hold_request = 200;
				burst_left = 40;
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// pause the sender mid-phase until the pipeline is empty
				if (p == 6 && n == PHASE_ITEMS / 2)
					drain_results();
				random_command(p == PHASES - 1, act, arg, duty);
				send_command(act, arg, duty, 1'b0, '0);
			end
		end
		calm = 1'b0;

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Sent %0d commands (%0d from the table) across %0d mode writes,",
			commands_sent, directed_count, mode_writes);
		$display("compared %0d results, %0d mismatched.", results_checked, mismatches);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
